>>> hw/rtl/ilid_pkg.sv
// Shared types and constants for the indexed list insert/delete block.
`default_nettype none
package ilid_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 12;
	localparam int COUNT_W      = 11;

	typedef enum logic [2:0] {
		CMD_GET      = 3'd0,
		CMD_ADD_HEAD = 3'd1,
		CMD_ADD_TAIL = 3'd2,
		CMD_INSERT   = 3'd3,
		CMD_DELETE   = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_BADIDX = 2'd1,
		ST_FULL   = 2'd2
	} status_e;

	typedef struct packed {
		logic [2:0]              cmd;
		logic signed [POS_W-1:0] position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [1:0]               status;
		logic [COUNT_W-1:0]       count;
	} rsp_t;

	// Per-cycle shift command broadcast along the cell row
	typedef struct packed {
		logic ins;
		logic del;
	} shift_t;

endpackage
`default_nettype wire

>>> hw/rtl/indexed_list_insert_delete.sv
// Top level: ordered list of signed words kept in a row of shifting cells.
`default_nettype none
// Usage
//   Command channel: req (cmd, position, value) is taken on a rising edge with
//   start high and busy low. busy is always low: a new command may follow every
//   cycle, so throughput is one transaction per clock.
//   Result channel: rsp (read_value, status, count) is valid for exactly one
//   cycle while done is high, in the cycle after the command edge.
//   The receiver cannot stall; every result must be taken when done pulses.
//   Storage: CAPACITY cells, each holding one element. An insert makes every
//   cell above the insert point copy its left neighbor while the target cell
//   loads the new value; a delete makes every cell at or above the point copy
//   its right neighbor. All cells move on the same clock edge, so the cost of
//   insert and delete does not depend on position. A get selects one cell directly.
//   Reset clears the element count and the result strobe; cell contents are
//   not cleared, since only positions below the count are ever read.
//   Bad positions, unused command codes and inserts into a full list leave
//   the contents unchanged and report through status with read_value of -1.
module indexed_list_insert_delete
	import ilid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	logic              accept;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_nxt;
	logic [COUNT_W-1:0] cnt_ext;
	logic              pos_neg;
	logic [COUNT_W-1:0] pos_mag;
	logic              pos_lt;     // 0 <= position < count
	logic              pos_le;     // 0 <= position <= count
	logic              full;
	logic [IW-1:0]     pos_idx;
	logic [IW-1:0]     cell_pos;
	shift_t            shift;
	logic [DATA_W-1:0] rd_val;
	logic [1:0]        st_val;
	logic [CAPACITY-1:0][DATA_W-1:0] cell_q;

	logic              done_q;
	logic [DATA_W-1:0] rd_q;
	logic [1:0]        st_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign cnt_ext = COUNT_W'(count_q);
	assign pos_neg = req.position[POS_W-1];
	assign pos_mag = req.position[COUNT_W-1:0];
	assign pos_lt  = !pos_neg && (pos_mag < cnt_ext);
	assign pos_le  = !pos_neg && (pos_mag <= cnt_ext);
	assign full    = (count_q == FULL_CNT);
	assign pos_idx = req.position[IW-1:0];

	// command decode
	always_comb begin
		shift     = '0;
		cell_pos  = pos_idx;
		rd_val    = '1;
		st_val    = ST_DONE;
		count_nxt = count_q;
		unique case (cmd_e'(req.cmd))
			CMD_GET: begin
				if (pos_lt) begin
					rd_val = cell_q[pos_idx];
				end else begin
					st_val = ST_BADIDX;
				end
			end
			CMD_ADD_HEAD: begin
				cell_pos = '0;
				if (full) begin
					st_val = ST_FULL;
				end else begin
					shift.ins = 1'b1;
				end
			end
			CMD_ADD_TAIL: begin
				cell_pos = count_q[IW-1:0];
				if (full) begin
					st_val = ST_FULL;
				end else begin
					shift.ins = 1'b1;
				end
			end
			CMD_INSERT: begin
				// negative position goes to the head
				if (pos_neg) begin
					cell_pos = '0;
				end
				if (!pos_neg && !pos_le) begin
					st_val = ST_BADIDX;
				end else if (full) begin
					st_val = ST_FULL;
				end else begin
					shift.ins = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (pos_lt) begin
					shift.del = 1'b1;
				end else begin
					st_val = ST_BADIDX;
				end
			end
			default: begin
				st_val = ST_BADIDX;
			end
		endcase
		if (!accept) begin
			shift = '0;
		end
		if (shift.ins) begin
			count_nxt = count_q + CW'(1);
		end else if (shift.del) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_val;
		logic [DATA_W-1:0] right_val;
		if (i == 0) begin : g_first
			assign left_val = req.value;
		end else begin : g_left
			assign left_val = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_val = cell_q[i];
		end else begin : g_right
			assign right_val = cell_q[i+1];
		end
		ilid_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i),
			.IW       (IW)
		) u_cell (
			.clk       (clk),
			.shift     (shift),
			.pos       (cell_pos),
			.new_val   (req.value),
			.left_val  (left_val),
			.right_val (right_val),
			.val_q     (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= rd_val;
			st_q <= st_val;
		end
	end

	assign done           = done_q;
	assign rsp.read_value = rd_q;
	assign rsp.status     = st_q;
	assign rsp.count      = COUNT_W'(count_q);

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("element count above capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("no result after accepted transaction");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without transaction");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> (count_q == FULL_CNT))
		else $error("full status with room left");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed while idle");

endmodule
`default_nettype wire

>>> hw/rtl/ilid_cell.sv
// One storage cell of the element row: hold, shift right, shift left or load.
`default_nettype none
module ilid_cell
	import ilid_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IDX      = 0,
	parameter int IW       = $clog2(CAPACITY)
) (
	input  wire logic              clk,
	input  wire shift_t            shift,
	input  wire logic [IW-1:0]     pos,
	input  wire logic [DATA_W-1:0] new_val,
	input  wire logic [DATA_W-1:0] left_val,
	input  wire logic [DATA_W-1:0] right_val,
	output logic      [DATA_W-1:0] val_q
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	always_ff @(posedge clk) begin
		if (shift.ins) begin
			if (MY_IDX == pos) begin
				val_q <= new_val;
			end else if (MY_IDX > pos) begin
				val_q <= left_val;
			end
		end else if (shift.del) begin
			if (MY_IDX >= pos) begin
				val_q <= right_val;
			end
		end
	end

endmodule
`default_nettype wire
